// ===== rtl/ethernet_frame_receive_check_top_macros.svh =====
// Assertion macros used by the checker of the frame receive check block.
`ifndef ETHERNET_FRAME_RECEIVE_CHECK_TOP_MACROS_SVH
`define ETHERNET_FRAME_RECEIVE_CHECK_TOP_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define EFRC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("frame receive check assertion failed");

// Property checked on every rising clock edge, reset cycles included.
`define EFRC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("frame receive check assertion failed");

`endif

// ===== rtl/efrc_pkg.sv =====
package efrc_pkg;

   localparam int BYTE_W      = 8;
   localparam int MAC_W       = 48;
   localparam int LEN_W       = 16;
   localparam int ETYPE_W     = 16;
   localparam int CRC_W       = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 48;

   // result word: status, length, source address, EtherType, zero pad
   localparam int STATUS_W    = 2;
   localparam int RSP_FIELDS_W = STATUS_W + LEN_W + MAC_W + ETYPE_W;
   localparam int RSP_TDATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int LEN_LSB     = STATUS_W;
   localparam int SRC_LSB     = LEN_LSB + LEN_W;
   localparam int ETYPE_LSB   = SRC_LSB + MAC_W;

   localparam logic [CRC_W-1:0] CRC_SEED = 32'hFFFF_FFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

   localparam logic [MAC_W-1:0] STATION_MAC_RST = 48'd146848183148421;
   localparam logic [LEN_W-1:0] MIN_FRAME_RST   = 16'd64;
   localparam logic [LEN_W-1:0] MAX_FRAME_RST   = 16'd1518;
   localparam logic [LEN_W-1:0] LEN_SAT         = 16'hFFFF;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_SIZE_ERR = 2'd1,
      ST_FCS_ERR  = 2'd2,
      ST_DEST_ERR = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STATION_MAC = 2'd0,
      CSR_MIN_FRAME   = 2'd1,
      CSR_MAX_FRAME   = 2'd2
   } csr_index_type;

endpackage

// ===== rtl/ethernet_frame_receive_check_top.sv =====
// A result is presented from the result register once its final byte has passed the
//   input register; the byte-wise CRC update is one unrolled XOR network.
// Throughput: one byte per cycle while no final byte waits for the result register.
// Bytes that do not end a frame keep flowing while a result waits on the output.
// Reset (synchronous, active high) restores the register defaults, clears frame state
//   and empties both registers; no clearing pass is needed.
module ethernet_frame_receive_check_top (
   input  logic                               clock,
   input  logic                               reset,
   // slave side, tdata: frame_byte[7:0]; tlast: last_byte
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [efrc_pkg::BYTE_W-1:0]        req_tdata,
   input  logic                               req_tlast,
   // master side, tdata: frame_status[1:0], frame_length[17:2],
   //   source_mac[65:18], ether_type[81:66], zero pad[87:82]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [efrc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // register write port
   input  logic                               csr_we,
   input  logic [efrc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [efrc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import efrc_pkg::*;

   // One reflected CRC-32 byte step, eight shift/xor stages unrolled.
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
      end
      return c;
   endfunction

   // configuration registers
   logic [MAC_W-1:0] station_ff;
   logic [LEN_W-1:0] min_ff;
   logic [LEN_W-1:0] max_ff;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;

   // per-frame state
   logic [CRC_W-1:0]   crc_ff, crc_in;
   logic [LEN_W-1:0]   cnt_ff, cnt_in;
   logic [CRC_W-1:0]   tail_ff, tail_in;
   logic               dest_ff, dest_in;
   logic [MAC_W-1:0]   src_ff, src_in;
   logic [ETYPE_W-1:0] etype_ff, etype_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   // updated frame view for the byte in the input register
   logic [CRC_W-1:0]   crc_upd;
   logic [LEN_W-1:0]   cnt_upd;
   logic [CRC_W-1:0]   tail_upd;
   logic               dest_upd;
   logic [MAC_W-1:0]   src_upd;
   logic [ETYPE_W-1:0] etype_upd;
   logic [CRC_W-1:0]   fcs_rx;
   status_type         status;
   logic               consume;
   logic               req_xfer;

   // A final byte needs a free result register; any other byte moves on at once.
   assign consume    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || consume;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      dest_upd  = dest_ff;
      src_upd   = src_ff;
      etype_upd = etype_ff;
      // destination bytes against the station address, first byte highest
      for (int i = 0; i < 6; i++) begin
         if (cnt_ff == LEN_W'(i) && station_ff[8*(5-i) +: 8] != in_byte_ff) begin
            dest_upd = 1'b0;
         end
      end
      // capture source address and EtherType, first byte highest
      for (int i = 0; i < 6; i++) begin
         if (cnt_ff == LEN_W'(6 + i)) begin
            src_upd[8*(5-i) +: 8] = in_byte_ff;
         end
      end
      for (int i = 0; i < 2; i++) begin
         if (cnt_ff == LEN_W'(12 + i)) begin
            etype_upd[8*(1-i) +: 8] = in_byte_ff;
         end
      end
      // the CRC sees a byte once it leaves the four-byte delay
      crc_upd  = (cnt_ff >= LEN_W'(4)) ? crc_byte(crc_ff, tail_ff[31:24]) : crc_ff;
      tail_upd = {tail_ff[23:0], in_byte_ff};
      cnt_upd  = (cnt_ff == LEN_SAT) ? cnt_ff : cnt_ff + LEN_W'(1);
      // received FCS, least-significant byte first on the wire
      fcs_rx   = {tail_upd[7:0], tail_upd[15:8], tail_upd[23:16], tail_upd[31:24]};

      if (cnt_upd < min_ff || cnt_upd > max_ff) begin
         status = ST_SIZE_ERR;
      end else if (fcs_rx != ~crc_upd) begin
         status = ST_FCS_ERR;
      end else if (!dest_upd) begin
         status = ST_DEST_ERR;
      end else begin
         status = ST_OK;
      end
   end

   // next frame state: advance on every byte, return to defaults after the final one
   always_comb begin
      crc_in   = crc_ff;
      cnt_in   = cnt_ff;
      tail_in  = tail_ff;
      dest_in  = dest_ff;
      src_in   = src_ff;
      etype_in = etype_ff;
      if (consume) begin
         if (in_last_ff) begin
            crc_in   = CRC_SEED;
            cnt_in   = '0;
            tail_in  = '0;
            dest_in  = 1'b1;
            src_in   = '0;
            etype_in = '0;
         end else begin
            crc_in   = crc_upd;
            cnt_in   = cnt_upd;
            tail_in  = tail_upd;
            dest_in  = dest_upd;
            src_in   = src_upd;
            etype_in = etype_upd;
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (consume && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff   <= STATION_MAC_RST;
         min_ff       <= MIN_FRAME_RST;
         max_ff       <= MAX_FRAME_RST;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         crc_ff       <= CRC_SEED;
         cnt_ff       <= '0;
         tail_ff      <= '0;
         dest_ff      <= 1'b1;
         src_ff       <= '0;
         etype_ff     <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_STATION_MAC: station_ff <= csr_wdata;
               CSR_MIN_FRAME:   min_ff     <= csr_wdata[LEN_W-1:0];
               CSR_MAX_FRAME:   max_ff     <= csr_wdata[LEN_W-1:0];
               default:         ;
            endcase
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         crc_ff       <= crc_in;
         cnt_ff       <= cnt_in;
         tail_ff      <= tail_in;
         dest_ff      <= dest_in;
         src_ff       <= src_in;
         etype_ff     <= etype_in;
      end
   end

   // payload registers: hold until the next transfer or final byte
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (consume && in_last_ff) begin
         rsp_data_ff <= {(RSP_TDATA_W - RSP_FIELDS_W)'(0), etype_upd, src_upd, cnt_upd,
                         status};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/efrc_checker.sv =====
`include "ethernet_frame_receive_check_top_macros.svh"

module efrc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [efrc_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import efrc_pkg::*;

   // reset empties the result register
   `EFRC_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_tvalid)

   // a stalled result stays offered and unchanged
   `EFRC_ASSERT(a_rsp_hold_valid, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `EFRC_ASSERT(a_rsp_hold_data, clock, reset,
                rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))

   // every reported frame holds at least its final byte
   `EFRC_ASSERT(a_rsp_len_nonzero, clock, reset,
                rsp_tvalid |-> rsp_tdata[SRC_LSB-1:LEN_LSB] != '0)

   // pad bits above the EtherType stay zero
   `EFRC_ASSERT(a_rsp_pad_zero, clock, reset,
                rsp_tvalid |-> rsp_tdata[RSP_TDATA_W-1:RSP_FIELDS_W] == '0)

endmodule

bind ethernet_frame_receive_check_top efrc_checker u_efrc_checker (.*);
